### hw/rtl/bqc_pkg.sv
// Shared constants, coefficient ROMs, microcode and control types for the biquad cascade.
`timescale 1ns / 1ps

package bqc_pkg;

   localparam int SECTIONS     = 8;
   localparam int SAMPLE_WIDTH = 16;

   localparam int VAL_W     = 32;                  // Q8.24 internal values
   localparam int COEF_W    = 32;                  // Q2.30 coefficients
   localparam int FRAC_COEF = 30;
   localparam int IN_SHIFT  = 25 - SAMPLE_WIDTH;
   localparam int PROD_W    = VAL_W + COEF_W;
   localparam int RND_W     = PROD_W - FRAC_COEF;
   localparam int ACC_W     = 36;                  // xs - x2 - p1 - p2 never leaves 36 bits
   localparam int OUT_W     = VAL_W + 1 - IN_SHIFT;

   localparam int ROM_ROWS = 8;
   localparam int ROW_W    = $clog2(ROM_ROWS);
   localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int PC_W     = 3;

   // decimal in units of 1e-11 to Q2.30: d * 2^19 / 5^11, rounded
   localparam longint Q30_NUM  = 64'sd524288;
   localparam longint Q30_HALF = 64'sd24414062;
   localparam longint Q30_DEN  = 64'sd48828125;

   function automatic logic signed [COEF_W-1:0] q30(input longint d);
      return COEF_W'((d * Q30_NUM + Q30_HALF) / Q30_DEN);
   endfunction

   localparam logic signed [COEF_W-1:0] KK_ROM [ROM_ROWS] = '{
      q30(64'sd1573576559), q30(64'sd1558147139), q30(64'sd1563561852),
      q30(64'sd1550789858), q30(64'sd1554850491), q30(64'sd1546468388),
      q30(64'sd1548637214), q30(64'sd1545721946)
   };
   localparam logic signed [COEF_W-1:0] A1_ROM [ROM_ROWS] = '{
      q30(64'sd143221897300), q30(64'sd147441936900), q30(64'sd142735787600),
      q30(64'sd146316024800), q30(64'sd142724237700), q30(64'sd145117821300),
      q30(64'sd143177529500), q30(64'sd144018298900)
   };
   localparam logic signed [COEF_W-1:0] A2_ROM [ROM_ROWS] = '{
      q30(64'sd99379079920), q30(64'sd99399066320), q30(64'sd98246018350),
      q30(64'sd98293739620), q30(64'sd97397861220), q30(64'sd97445188990),
      q30(64'sd96955545820), q30(64'sd96975063210)
   };

   // program steps
   localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
   localparam logic [PC_W-1:0] PC_GAIN = 3'd1;
   localparam logic [PC_W-1:0] PC_XS   = 3'd2;
   localparam logic [PC_W-1:0] PC_ACC  = 3'd3;
   localparam logic [PC_W-1:0] PC_UPD  = 3'd4;
   localparam logic [PC_W-1:0] PC_EMIT = 3'd5;

   typedef enum logic [1:0] {
      MUL_X_KK,
      MUL_Y1_A1,
      MUL_Y2_A2
   } mul_sel_type;

   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_LOAD,
      ALU_GAIN,
      ALU_ACC,
      ALU_UPDATE
   } alu_op_type;

   typedef enum logic [1:0] {
      JMP_ALWAYS,
      JMP_WAIT_REQ,
      JMP_LOOP,
      JMP_WAIT_OUT
   } jump_type;

   typedef struct packed {
      logic              accept;
      logic              emit;
      mul_sel_type       mul_sel;
      alu_op_type        alu_op;
      jump_type          jump;
      logic [PC_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      mul_sel_type       mul_sel;
      alu_op_type        alu_op;
      logic              load;
      logic [SEC_W-1:0]  sec;
   } dp_ctl_type;

   // JMP_LOOP: fall through on the last section, else go to target
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{accept: 1'b0, emit: 1'b0, mul_sel: MUL_X_KK, alu_op: ALU_NOP,
            jump: JMP_ALWAYS, target: PC_IDLE};
      case (pc)
         PC_IDLE: begin
            w.accept = 1'b1;
            w.alu_op = ALU_LOAD;
            w.jump   = JMP_WAIT_REQ;
            w.target = PC_GAIN;
         end
         PC_GAIN: begin
            w.mul_sel = MUL_X_KK;
            w.target  = PC_XS;
         end
         PC_XS: begin
            w.mul_sel = MUL_Y1_A1;
            w.alu_op  = ALU_GAIN;
            w.target  = PC_ACC;
         end
         PC_ACC: begin
            w.mul_sel = MUL_Y2_A2;
            w.alu_op  = ALU_ACC;
            w.target  = PC_UPD;
         end
         PC_UPD: begin
            w.alu_op = ALU_UPDATE;
            w.jump   = JMP_LOOP;
            w.target = PC_GAIN;
         end
         PC_EMIT: begin
            w.emit   = 1'b1;
            w.jump   = JMP_WAIT_OUT;
            w.target = PC_IDLE;
         end
         default: begin
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/bqc_if.sv
// Valid/ready channel interfaces for the sample input and the filtered output.
`timescale 1ns / 1ps

interface bqc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] sample_in;
   logic                                    block_end_in;

   modport source (output valid, output sample_in, output block_end_in, input ready);
   modport sink   (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface bqc_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] sample_out;
   logic                                    block_end_out;

   modport source (output valid, output sample_out, output block_end_out, input ready);
   modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

### hw/rtl/biquad_cascade_bandpass_core.sv
// Top level: microcoded sequencer, result register and the biquad cascade datapath.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      sample_in (Q1.15), block_end_in
//   rsp_ch    out   valid / ready      sample_out (Q1.15), block_end_out
//
// Each item runs one accept step, then four microcode steps per section on the
// single shared 32x32 multiplier (gain, a1 and a2 products, then update), and
// one emit step.
// Synchronous active-high reset clears all section delays and the sequencer.
// The result sits in an output register; the next item is taken while it waits,
// and only the emit step stalls if the previous result has not been taken.
`timescale 1ns / 1ps

module biquad_cascade_bandpass_core (
   input  logic       clock,
   input  logic       reset,
   bqc_req_if.sink    req_ch,
   bqc_rsp_if.source  rsp_ch
);

   localparam int SW = bqc_pkg::SAMPLE_WIDTH;

   logic [bqc_pkg::PC_W-1:0]  pc_ff;
   logic [bqc_pkg::PC_W-1:0]  pc_in;
   logic [bqc_pkg::SEC_W-1:0] sec_ff;
   logic [bqc_pkg::SEC_W-1:0] sec_in;
   logic                      be_ff;
   logic                      be_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [SW-1:0]      rsp_sample_ff;
   logic signed [SW-1:0]      rsp_sample_in;
   logic                      rsp_be_ff;
   logic                      rsp_be_in;

   bqc_pkg::ucode_type        uc;
   bqc_pkg::dp_ctl_type       dp_ctl;
   logic                      req_fire;
   logic                      out_free;
   logic                      last_sec;
   logic                      emit_fire;
   logic signed [SW-1:0]      dp_result;

   assign uc        = bqc_pkg::ucode_rom(pc_ff);
   assign req_fire  = req_ch.valid && uc.accept;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign last_sec  = (sec_ff == bqc_pkg::SEC_W'(bqc_pkg::SECTIONS - 1));
   assign emit_fire = uc.emit && out_free;

   assign dp_ctl = '{mul_sel: uc.mul_sel, alu_op: uc.alu_op, load: req_fire, sec: sec_ff};

   bqc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dp_ctl),
      .sample_in (req_ch.sample_in),
      .result    (dp_result)
   );

   always_comb begin
      case (uc.jump)
         bqc_pkg::JMP_ALWAYS:   pc_in = uc.target;
         bqc_pkg::JMP_WAIT_REQ: pc_in = req_fire ? uc.target : pc_ff;
         bqc_pkg::JMP_LOOP:     pc_in = last_sec ? pc_ff + bqc_pkg::PC_W'(1) : uc.target;
         bqc_pkg::JMP_WAIT_OUT: pc_in = out_free ? uc.target : pc_ff;
         default:               pc_in = bqc_pkg::PC_IDLE;
      endcase

      sec_in = sec_ff;
      if (req_fire) begin
         sec_in = '0;
      end else if (uc.alu_op == bqc_pkg::ALU_UPDATE) begin
         sec_in = last_sec ? '0 : sec_ff + bqc_pkg::SEC_W'(1);
      end

      be_in = req_fire ? req_ch.block_end_in : be_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_be_in     = rsp_be_ff;
      if (emit_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = dp_result;
         rsp_be_in     = be_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= bqc_pkg::PC_IDLE;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      be_ff         <= be_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_be_ff     <= rsp_be_in;
   end

   assign req_ch.ready         = uc.accept;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sample_out    = rsp_sample_ff;
   assign rsp_ch.block_end_out = rsp_be_ff;

   a_accept_starts_gain : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (pc_ff == bqc_pkg::PC_GAIN) && (sec_ff == '0))
      else $error("accepted item did not start at the first section gain step");

   a_result_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == bqc_pkg::PC_EMIT)
      else $error("result appeared outside the emit step");

   a_emit_holds_when_busy : assert property (@(posedge clock) disable iff (reset)
      (uc.emit && rsp_valid_ff && !rsp_ch.ready) |=> (pc_ff == bqc_pkg::PC_EMIT) && rsp_valid_ff)
      else $error("emit step left while the result register was still full");

   a_sec_in_range : assert property (@(posedge clock) disable iff (reset)
      sec_ff <= bqc_pkg::SEC_W'(bqc_pkg::SECTIONS - 1))
      else $error("section counter out of range");

   a_last_section_emits : assert property (@(posedge clock) disable iff (reset)
      (pc_ff == bqc_pkg::PC_UPD && last_sec) |=> pc_ff == bqc_pkg::PC_EMIT)
      else $error("last section update did not lead to the emit step");

endmodule

### hw/rtl/bqc_datapath.sv
// Shared-multiplier datapath: section delays, rounding, accumulate and saturation.
`timescale 1ns / 1ps

module bqc_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bqc_pkg::dp_ctl_type                     ctl,
   input  logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] result
);

   localparam int VW        = bqc_pkg::VAL_W;
   localparam int SW        = bqc_pkg::SAMPLE_WIDTH;
   localparam int OW        = bqc_pkg::OUT_W;
   localparam int SEC_EXT_W = bqc_pkg::SEC_W + bqc_pkg::ROW_W;

   typedef struct packed {
      logic signed [VW-1:0] x1;
      logic signed [VW-1:0] x2;
      logic signed [VW-1:0] y1;
      logic signed [VW-1:0] y2;
   } dly_row_type;

   localparam logic signed [OW-1:0] O_MAX = OW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [OW-1:0] O_MIN = -O_MAX - OW'(1);

   dly_row_type                           dly_ff [bqc_pkg::SECTIONS];
   dly_row_type                           cur;
   logic signed [VW-1:0]                  x_ff;
   logic signed [VW-1:0]                  xs_ff;
   logic signed [bqc_pkg::ACC_W-1:0]      acc_ff;
   logic signed [bqc_pkg::PROD_W-1:0]     prod_ff;
   logic signed [bqc_pkg::PROD_W-1:0]     prod_in;
   logic signed [VW-1:0]                  mul_a;
   logic signed [bqc_pkg::COEF_W-1:0]     mul_c;
   logic [SEC_EXT_W-1:0]                  sec_ext;
   logic [bqc_pkg::ROW_W-1:0]             row;
   logic signed [bqc_pkg::RND_W-1:0]      prod_rnd;
   logic signed [bqc_pkg::ACC_W-1:0]      acc_next;
   logic signed [VW-1:0]                  y_new;
   logic signed [VW:0]                    out_biased;
   logic signed [OW-1:0]                  out_full;
   logic signed [VW-1:0]                  x_load;

   function automatic logic signed [VW-1:0] sat_val(input logic signed [bqc_pkg::ACC_W-1:0] v);
      logic signed [bqc_pkg::ACC_W-1:0] hi;
      logic signed [bqc_pkg::ACC_W-1:0] lo;
      hi = bqc_pkg::ACC_W'({1'b0, {(VW-1){1'b1}}});
      lo = -hi - bqc_pkg::ACC_W'(1);
      if (v > hi) begin
         return {1'b0, {(VW-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(VW-1){1'b0}}};
      end
      return v[VW-1:0];
   endfunction

   assign cur     = dly_ff[ctl.sec];
   assign sec_ext = {{bqc_pkg::ROW_W{1'b0}}, ctl.sec};
   assign row     = sec_ext[bqc_pkg::ROW_W-1:0];   // rows repeat beyond the ROM depth

   always_comb begin
      case (ctl.mul_sel)
         bqc_pkg::MUL_X_KK: begin
            mul_a = x_ff;
            mul_c = bqc_pkg::KK_ROM[row];
         end
         bqc_pkg::MUL_Y1_A1: begin
            mul_a = cur.y1;
            mul_c = bqc_pkg::A1_ROM[row];
         end
         bqc_pkg::MUL_Y2_A2: begin
            mul_a = cur.y2;
            mul_c = bqc_pkg::A2_ROM[row];
         end
         default: begin
            mul_a = x_ff;
            mul_c = bqc_pkg::KK_ROM[row];
         end
      endcase
   end

   assign prod_in = bqc_pkg::PROD_W'(mul_a) * bqc_pkg::PROD_W'(mul_c);

   // round half up: add half, then floor
   always_comb begin
      logic signed [bqc_pkg::PROD_W-1:0] biased;
      biased   = prod_ff + (bqc_pkg::PROD_W'(1) <<< (bqc_pkg::FRAC_COEF - 1));
      prod_rnd = biased[bqc_pkg::PROD_W-1:bqc_pkg::FRAC_COEF];
   end

   // b0 = 1 passes xs unchanged, b2 = -1 subtracts x2 exactly, b1 = 0 drops out
   assign acc_next = bqc_pkg::ACC_W'(xs_ff) - bqc_pkg::ACC_W'(cur.x2)
                   - bqc_pkg::ACC_W'(prod_rnd);
   assign y_new    = sat_val(acc_ff - bqc_pkg::ACC_W'(prod_rnd));

   assign x_load = {{(VW - SW - bqc_pkg::IN_SHIFT){sample_in[SW-1]}}, sample_in,
                    {bqc_pkg::IN_SHIFT{1'b0}}};

   assign out_biased = (VW+1)'(x_ff) + ((VW+1)'(1) <<< (bqc_pkg::IN_SHIFT - 1));
   assign out_full   = out_biased[VW:bqc_pkg::IN_SHIFT];

   always_comb begin
      if (out_full > O_MAX) begin
         result = O_MAX[SW-1:0];
      end else if (out_full < O_MIN) begin
         result = O_MIN[SW-1:0];
      end else begin
         result = out_full[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl.load) begin
         x_ff <= x_load;
      end else if (ctl.alu_op == bqc_pkg::ALU_UPDATE) begin
         x_ff <= y_new;
      end
      if (ctl.alu_op == bqc_pkg::ALU_GAIN) begin
         xs_ff <= sat_val(bqc_pkg::ACC_W'(prod_rnd));
      end
      if (ctl.alu_op == bqc_pkg::ALU_ACC) begin
         acc_ff <= acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bqc_pkg::SECTIONS; i++) begin
            dly_ff[i] <= '0;
         end
      end else if (ctl.alu_op == bqc_pkg::ALU_UPDATE) begin
         dly_ff[ctl.sec] <= '{x1: xs_ff, x2: cur.x1, y1: y_new, y2: cur.y1};
      end
   end

endmodule
